FILE: rtl/mtr_pkg.sv
package mtr_pkg;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_DELAY_OFFSET  = 3'd0;
   localparam logic [2:0] CSR_RESYNC_SHIFT  = 3'd1;
   localparam logic [2:0] CSR_RATE_NUM      = 3'd2;
   localparam logic [2:0] CSR_RATE_DEN      = 3'd3;
   localparam logic [2:0] CSR_IN_TIMESCALE  = 3'd4;
   localparam logic [2:0] CSR_STREAM_CLASS  = 3'd5;
   localparam logic [2:0] CSR_FRAME_MODE    = 3'd6;
   localparam logic [2:0] CSR_ALIGN_THRESH  = 3'd7;

   // stream classes and frame actions
   localparam logic [1:0] CLASS_VIDEO  = 2'd0;
   localparam logic [1:0] ACT_NEW      = 2'd0;
   localparam logic [1:0] ACT_REPEAT   = 2'd1;
   localparam logic [1:0] ACT_DROP     = 2'd2;

   // milliseconds per second
   localparam logic [63:0] MS_PER_SEC  = 64'd1000;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WAIT,
      ST_NEG1,
      ST_NEG2,
      ST_POS,
      ST_RC1,
      ST_RC2,
      ST_RC3,
      ST_NC1,
      ST_NC2,
      ST_NC3,
      ST_NC3B,
      ST_NC4,
      ST_NC5,
      ST_ALIGN,
      ST_AL_SRS,
      ST_AL_PRED,
      ST_AL_CMP,
      ST_RS0,
      ST_RS1,
      ST_RS2,
      ST_RS3,
      ST_RS4,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/mtr_alu.sv
module mtr_alu (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mtr_pkg::alu_op_type op,
   input  logic [63:0]         opa,
   input  logic [63:0]         opb,
   output logic                done,
   output logic [63:0]         quo,
   output logic [63:0]         rem
);
   import mtr_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   alu_op_type  op_ff, op_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] sh_ff, sh_in;
   logic [63:0] b_ff, b_in;
   logic [64:0] trial;
   logic [64:0] diff;

   // one bit per cycle: shift-add multiply (mod 2^64) or restoring divide
   always_comb begin
      trial   = {rem_ff, sh_ff[63]};
      diff    = trial - {1'b0, b_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = op;
         sh_in   = opa;
         b_in    = opb;
         acc_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == ALU_MUL) begin
            if (b_ff[0]) begin
               acc_in = acc_ff + sh_ff;
            end
            sh_in = sh_ff << 1;
            b_in  = b_ff >> 1;
         end else begin
            sh_in = sh_ff << 1;
            if (!diff[64]) begin
               rem_in = diff[63:0];
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = trial[63:0];
               acc_in = {acc_ff[62:0], 1'b0};
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign quo  = acc_ff;
   assign rem  = rem_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("alu started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("alu done without run");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff) else $error("alu start did not run");

endmodule

FILE: rtl/media_timestamp_restamper_unit.sv
// channel  | ports                       | payload
// ---------+-----------------------------+-----------------------------------
// request  | req_tvalid/tready/tdata/user| orig_ts, pkt_duration; ts_present,
//          |                             | is_reference
// response | rsp_tvalid/tready/tdata/user| new_ts; ts_valid, frame_action
// config   | csr_we/csr_index/csr_wdata  | eight registers, write only
//
// one beat at a time; each multiply or divide runs on the shared 64-bit unit;
// a beat without a timestamp skips all arithmetic, and the longest path is a
// rescaled video frame copy plus alignment with rescaling.
// reset is synchronous and restores the register defaults and clears state.
// a finished result waits in the response register; the next beat is taken
// while it waits, and a new result waits until the old one is taken.
module media_timestamp_restamper_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // orig_ts[63:0], pkt_duration[95:64]
   input  logic [1:0]   req_tuser,   // ts_present[0], is_reference[1]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // new_ts[63:0]
   output logic [2:0]   rsp_tuser,   // ts_valid[0], frame_action[2:1]
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_wdata
);
   import mtr_pkg::*;

   // configuration
   logic [39:0] delay_ff;
   logic [47:0] resync_ff;
   logic [16:0] num_ff;
   logic [15:0] den_ff;
   logic [31:0] tsc_ff;
   logic [1:0]  cls_ff;
   logic [1:0]  mode_ff;
   logic [31:0] thr_ff;

   // sequencer and item
   state_type   state_ff, state_in, ret_ff, ret_in, sub_ff, sub_in;
   logic        present_ff, present_in, isref_ff, isref_in;
   logic [31:0] pdur_ff, pdur_in;
   logic [63:0] ots_ff, ots_in, ts_ff, ts_in;
   logic [1:0]  act_ff, act_in;
   logic [63:0] d_ff, d_in, fd_ff, fd_in, n_ff, n_in;
   logic        neg_ff, neg_in;
   logic [31:0] dur_ff, dur_in;
   logic [63:0] pred_ff, pred_in;
   logic [63:0] rsv_ff, rsv_in, rsfrom_ff, rsfrom_in, rsto_ff, rsto_in;
   logic [63:0] rsacc_ff, rsacc_in, rsrem_ff, rsrem_in, rsres_ff, rsres_in;

   // persistent state
   logic [63:0] first_ff, first_in, start_ff, start_in, prev_ff, prev_in;
   logic [63:0] pref_ff, pref_in, carry_ff, carry_in;
   logic [31:0] ss_ff, ss_in, fs_ff, fs_in, srs_ff, srs_in;

   // response register
   logic        rv_ff, rv_in, rtv_ff, rtv_in;
   logic [63:0] rts_ff, rts_in;
   logic [1:0]  ract_ff, ract_in;

   // shared unit
   logic        alu_start, alu_done;
   alu_op_type  alu_op;
   logic [63:0] alu_a, alu_b, alu_q, alu_r;

   // derived values
   logic [63:0] numv, num_mag, den64, tsc64, tsr, base, diffv, tmp, dm, half;
   logic        num_pos, video, rawcopy, resc, dcond;
   logic [31:0] d2;

   mtr_alu u_alu (
      .clock (clock),
      .reset (reset),
      .start (alu_start),
      .op    (alu_op),
      .opa   (alu_a),
      .opb   (alu_b),
      .done  (alu_done),
      .quo   (alu_q),
      .rem   (alu_r)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= '0;
         resync_ff <= '0;
         num_ff    <= '0;
         den_ff    <= 16'd1;
         tsc_ff    <= 32'd1000;
         cls_ff    <= 2'd2;
         mode_ff   <= '0;
         thr_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DELAY_OFFSET: delay_ff  <= csr_wdata[39:0];
            CSR_RESYNC_SHIFT: resync_ff <= csr_wdata;
            CSR_RATE_NUM:     num_ff    <= csr_wdata[16:0];
            CSR_RATE_DEN:     den_ff    <= csr_wdata[15:0];
            CSR_IN_TIMESCALE: tsc_ff    <= csr_wdata[31:0];
            CSR_STREAM_CLASS: cls_ff    <= csr_wdata[1:0];
            CSR_FRAME_MODE:   mode_ff   <= csr_wdata[1:0];
            CSR_ALIGN_THRESH: thr_ff    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // decoded configuration
   always_comb begin
      numv    = {{47{num_ff[16]}}, num_ff};
      num_mag = 64'd0 - numv;
      num_pos = !num_ff[16] && (num_ff != 17'd0);
      den64   = {48'd0, den_ff};
      tsc64   = {32'd0, tsc_ff};
      video   = (cls_ff == CLASS_VIDEO);
      rawcopy = mode_ff[0] && video;
      resc    = mode_ff[1] && num_pos;
      tsr     = resc ? numv : tsc64;
      base    = first_ff - 64'd1;
      diffv   = ts_ff - base;
   end

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      sub_in     = sub_ff;
      present_in = present_ff;
      isref_in   = isref_ff;
      pdur_in    = pdur_ff;
      ots_in     = ots_ff;
      ts_in      = ts_ff;
      act_in     = act_ff;
      d_in       = d_ff;
      fd_in      = fd_ff;
      n_in       = n_ff;
      neg_in     = neg_ff;
      dur_in     = dur_ff;
      pred_in    = pred_ff;
      rsv_in     = rsv_ff;
      rsfrom_in  = rsfrom_ff;
      rsto_in    = rsto_ff;
      rsacc_in   = rsacc_ff;
      rsrem_in   = rsrem_ff;
      rsres_in   = rsres_ff;
      first_in   = first_ff;
      start_in   = start_ff;
      prev_in    = prev_ff;
      pref_in    = pref_ff;
      carry_in   = carry_ff;
      ss_in      = ss_ff;
      fs_in      = fs_ff;
      srs_in     = srs_ff;
      rv_in      = rv_ff && !rsp_tready;
      rtv_in     = rtv_ff;
      rts_in     = rts_ff;
      ract_in    = ract_ff;
      alu_start  = 1'b0;
      alu_op     = ALU_MUL;
      alu_a      = '0;
      alu_b      = '0;
      tmp        = '0;
      dm         = '0;
      half       = {33'd0, ss_ff[31:1]};
      dcond      = 1'b0;
      d2         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               present_in = req_tuser[0];
               isref_in   = req_tuser[1];
               pdur_in    = req_tdata[95:64];
               tmp        = req_tdata[63:0] + {{16{resync_ff[47]}}, resync_ff};
               ots_in     = tmp;
               ts_in      = tmp + {24'd0, delay_ff};
               act_in     = ACT_NEW;
               state_in   = req_tuser[0] ? ST_EVAL : ST_DONE;
            end
         end

         // first timestamp, or choose the rate path
         ST_EVAL: begin
            state_in = ST_ALIGN;
            if (video && num_ff != 17'd0) begin
               if (first_ff == 64'd0) begin
                  first_in = ts_ff + 64'd1;
                  start_in = ts_ff + 64'd1;
                  if (rawcopy) act_in = ACT_REPEAT;
               end else if (num_ff[16]) begin
                  alu_start = 1'b1;
                  alu_op    = ALU_MUL;
                  alu_a     = diffv;
                  alu_b     = den64;
                  ret_in    = ST_NEG1;
                  state_in  = ST_WAIT;
               end else if ((ots_ff + 64'd1) > start_ff) begin
                  tmp  = ots_ff - (start_ff - 64'd1);
                  d_in = tmp;
                  if (ss_ff == 32'd0 || tmp < {32'd0, ss_ff}) ss_in = tmp[31:0];
                  state_in = ST_POS;
               end
            end
         end

         ST_WAIT: begin
            if (alu_done) state_in = ret_ff;
         end

         // speed factor: scale elapsed time
         ST_NEG1: begin
            neg_in    = alu_q[63];
            alu_start = 1'b1;
            alu_op    = ALU_DIV;
            alu_a     = alu_q[63] ? (64'd0 - alu_q) : alu_q;
            alu_b     = num_mag;
            ret_in    = ST_NEG2;
            state_in  = ST_WAIT;
         end

         ST_NEG2: begin
            ts_in    = base + (neg_ff ? (64'd0 - alu_q) : alu_q);
            state_in = ST_ALIGN;
         end

         ST_POS: begin
            if (rawcopy) begin
               alu_start = 1'b1;
               alu_op    = ALU_MUL;
               alu_a     = {32'd0, fs_ff};
               alu_b     = den64;
               ret_in    = ST_RC1;
               state_in  = ST_WAIT;
            end else if (ss_ff == 32'd0) begin
               ts_in    = base;
               state_in = ST_ALIGN;
            end else begin
               neg_in    = diffv[63];
               alu_start = 1'b1;
               alu_op    = ALU_DIV;
               alu_a     = diffv[63] ? (64'd0 - diffv) : diffv;
               alu_b     = {32'd0, ss_ff};
               ret_in    = ST_NC1;
               state_in  = ST_WAIT;
            end
         end

         // frame copy: expected time of the next frame
         ST_RC1: begin
            fd_in     = alu_q;
            alu_start = 1'b1;
            alu_op    = ALU_MUL;
            alu_a     = alu_q;
            alu_b     = tsc64;
            ret_in    = ST_RC2;
            state_in  = ST_WAIT;
         end

         ST_RC2: begin
            alu_start = 1'b1;
            alu_op    = ALU_DIV;
            alu_a     = alu_q;
            alu_b     = numv;
            ret_in    = ST_RC3;
            state_in  = ST_WAIT;
         end

         ST_RC3: begin
            state_in = ST_ALIGN;
            if ((alu_q + half) <= d_ff) begin
               act_in = ACT_REPEAT;
               ts_in  = (resc ? fd_ff : alu_q) + base;
            end else if ((d_ff + half) <= alu_q) begin
               act_in = ACT_DROP;
               ts_in  = '0;
            end else begin
               ts_in  = (resc ? fd_ff : alu_q) + base;
            end
         end

         // snap to whole frames
         ST_NC1: begin
            n_in = neg_ff ? (64'd0 - alu_q) : alu_q;
            if (resc) begin
               state_in = ST_NC4;
            end else if (tsc_ff == 32'd0) begin
               n_in     = '0;
               state_in = ST_NC4;
            end else begin
               alu_start = 1'b1;
               alu_op    = ALU_MUL;
               alu_a     = {32'd0, ss_ff};
               alu_b     = numv;
               ret_in    = ST_NC2;
               state_in  = ST_WAIT;
            end
         end

         ST_NC2: begin
            alu_start = 1'b1;
            alu_op    = ALU_DIV;
            alu_a     = alu_q;
            alu_b     = tsc64;
            ret_in    = ST_NC3;
            state_in  = ST_WAIT;
         end

         ST_NC3: begin
            alu_start = 1'b1;
            alu_op    = ALU_MUL;
            alu_a     = n_ff;
            alu_b     = alu_q;
            ret_in    = ST_NC3B;
            state_in  = ST_WAIT;
         end

         ST_NC3B: begin
            n_in     = alu_q;
            state_in = ST_NC4;
         end

         ST_NC4: begin
            alu_start = 1'b1;
            alu_op    = ALU_MUL;
            alu_a     = n_ff;
            alu_b     = den64;
            ret_in    = ST_NC5;
            state_in  = ST_WAIT;
         end

         ST_NC5: begin
            ts_in    = base + alu_q;
            state_in = ST_ALIGN;
         end

         // alignment: none at a zero threshold, else reference step or carry the last shift
         ST_ALIGN: begin
            if (thr_ff == 32'd0) begin
               state_in = ST_DONE;
            end else if (!isref_ff) begin
               ts_in    = ts_ff + carry_ff;
               state_in = ST_DONE;
            end else begin
               tmp   = ots_ff - prev_ff;
               dcond = (pdur_ff == 32'd0) ||
                       ((prev_ff < ots_ff) && ({32'd0, pdur_ff} > tmp));
               d2      = dcond ? tmp[31:0] : pdur_ff;
               dur_in  = d2;
               prev_in = ots_ff;
               if (resc) begin
                  rsv_in    = {32'd0, d2};
                  rsfrom_in = tsc64;
                  rsto_in   = numv;
                  sub_in    = ST_AL_SRS;
                  state_in  = ST_RS0;
               end else begin
                  state_in = ST_AL_SRS;
               end
            end
         end

         ST_AL_SRS: begin
            d2 = resc ? rsres_ff[31:0] : dur_ff;
            if (d2 != 32'd0 && (srs_ff == 32'd0 || d2 < srs_ff)) srs_in = d2;
            if (pref_ff != 64'd0) begin
               state_in = ST_AL_PRED;
            end else begin
               pref_in  = ts_ff + 64'd1;
               state_in = ST_DONE;
            end
         end

         ST_AL_PRED: begin
            tmp       = pref_ff - 64'd1 + {32'd0, srs_ff};
            pred_in   = tmp;
            dm        = ts_ff - tmp;
            neg_in    = dm[63];
            rsv_in    = dm[63] ? (64'd0 - dm) : dm;
            rsfrom_in = tsr;
            rsto_in   = MS_PER_SEC;
            sub_in    = ST_AL_CMP;
            state_in  = ST_RS0;
         end

         ST_AL_CMP: begin
            dm       = neg_ff ? (64'd0 - rsres_ff) : rsres_ff;
            tmp      = dm[63] ? (64'd0 - dm) : dm;
            carry_in = '0;
            pref_in  = ts_ff + 64'd1;
            if (tmp > {32'd0, thr_ff}) begin
               carry_in = pred_ff - ts_ff;
               ts_in    = pred_ff;
               pref_in  = pred_ff + 64'd1;
            end
            state_in = ST_DONE;
         end

         // rescale subroutine: v * to / from without overflow
         ST_RS0: begin
            if (rsfrom_ff == rsto_ff) begin
               rsres_in = rsv_ff;
               state_in = sub_ff;
            end else if (rsfrom_ff == 64'd0) begin
               rsres_in = '0;
               state_in = sub_ff;
            end else begin
               alu_start = 1'b1;
               alu_op    = ALU_DIV;
               alu_a     = rsv_ff;
               alu_b     = rsfrom_ff;
               ret_in    = ST_RS1;
               state_in  = ST_WAIT;
            end
         end

         ST_RS1: begin
            rsrem_in  = alu_r;
            alu_start = 1'b1;
            alu_op    = ALU_MUL;
            alu_a     = alu_q;
            alu_b     = rsto_ff;
            ret_in    = ST_RS2;
            state_in  = ST_WAIT;
         end

         ST_RS2: begin
            rsacc_in  = alu_q;
            alu_start = 1'b1;
            alu_op    = ALU_MUL;
            alu_a     = rsrem_ff;
            alu_b     = rsto_ff;
            ret_in    = ST_RS3;
            state_in  = ST_WAIT;
         end

         ST_RS3: begin
            alu_start = 1'b1;
            alu_op    = ALU_DIV;
            alu_a     = alu_q;
            alu_b     = rsfrom_ff;
            ret_in    = ST_RS4;
            state_in  = ST_WAIT;
         end

         ST_RS4: begin
            rsres_in = rsacc_ff + alu_q;
            state_in = sub_ff;
         end

         // hand the result to the response register
         ST_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in   = 1'b1;
               rtv_in  = present_ff;
               rts_in  = present_ff ? ts_ff : 64'd0;
               ract_in = act_ff;
               if (rawcopy && act_ff != ACT_DROP) fs_in = fs_ff + 32'd1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         first_ff <= '0;
         start_ff <= '0;
         prev_ff  <= '0;
         pref_ff  <= '0;
         carry_ff <= '0;
         ss_ff    <= '0;
         fs_ff    <= '0;
         srs_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         first_ff <= first_in;
         start_ff <= start_in;
         prev_ff  <= prev_in;
         pref_ff  <= pref_in;
         carry_ff <= carry_in;
         ss_ff    <= ss_in;
         fs_ff    <= fs_in;
         srs_ff   <= srs_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      sub_ff     <= sub_in;
      present_ff <= present_in;
      isref_ff   <= isref_in;
      pdur_ff    <= pdur_in;
      ots_ff     <= ots_in;
      ts_ff      <= ts_in;
      act_ff     <= act_in;
      d_ff       <= d_in;
      fd_ff      <= fd_in;
      n_ff       <= n_in;
      neg_ff     <= neg_in;
      dur_ff     <= dur_in;
      pred_ff    <= pred_in;
      rsv_ff     <= rsv_in;
      rsfrom_ff  <= rsfrom_in;
      rsto_ff    <= rsto_in;
      rsacc_ff   <= rsacc_in;
      rsrem_ff   <= rsrem_in;
      rsres_ff   <= rsres_in;
      rtv_ff     <= rtv_in;
      rts_ff     <= rts_in;
      ract_ff    <= ract_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rts_ff;
   assign rsp_tuser  = {ract_ff, rtv_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("accepted twice");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == ST_WAIT) else $error("alu result unused");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response lost");
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] == ACT_DROP && thr_ff == 32'd0
      |-> rsp_tdata == 64'd0) else $error("dropped frame with timestamp");

endmodule
